>>> hw/rtl/fbf_pkg.sv
// ----------------------------------------------------------------------------
// fbf_pkg: shared definitions for the FIR band-pass filter unit
// Sizes of the sample, coefficient and accumulator paths, request codes and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package fbf_pkg;

    localparam int MAX_TAPS     = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;
    localparam int TAP_IDX_W    = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W    = 7;
    localparam int PROD_W       = SAMPLE_WIDTH + COEF_WIDTH;
    // Products plus growth for MAX_TAPS terms, two spare bits.
    localparam int ACC_W        = PROD_W + TAP_IDX_W + 2;
    localparam int ROUND_SHIFT  = COEF_WIDTH - 1;

    // Request type codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef struct packed {
        logic                 coef_wr;    // store a coefficient
        logic                 smp_wr;     // store a sample and clear the accumulator
        logic                 issue;      // read one tap pair into the MAC pipeline
        logic [TAP_IDX_W-1:0] tap_idx;    // tap position being read
        logic                 load_out;   // capture the result, advance the pointer
    } fbf_cmd_t;

    typedef struct packed {
        logic pipe_busy;                  // MAC pipeline still holds terms
    } fbf_status_t;

endpackage

>>> hw/rtl/fbf_ctrl.sv
// ----------------------------------------------------------------------------
// fbf_ctrl: sequencer of the FIR band-pass filter unit
// Accepts requests, walks the taps of one sample through the shared MAC and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module fbf_ctrl
    import fbf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 cfg_we,
    input  logic [TAP_CNT_W-1:0] cfg_wdata,
    input  fbf_status_t          status,
    output fbf_cmd_t             cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [TAP_CNT_W-1:0] tap_count_reg;
    logic [TAP_CNT_W-1:0] tap_reg, tap_next;
    logic                 m_valid_reg, m_valid_next;
    logic [TAP_CNT_W-1:0] taps_eff;
    logic                 accept;

    assign taps_eff = (tap_count_reg > TAP_CNT_W'(MAX_TAPS)) ? TAP_CNT_W'(MAX_TAPS)
                                                              : tap_count_reg;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.tap_idx  = tap_reg[TAP_IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_req_type == REQ_COEF) begin
                        cmd.coef_wr = 1'b1;
                    end else begin
                        cmd.smp_wr = 1'b1;
                        tap_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (taps_eff == '0) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.issue = 1'b1;
                    tap_next  = tap_reg + TAP_CNT_W'(1);
                    if (tap_reg == taps_eff - TAP_CNT_W'(1)) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy && (!m_valid_reg || m_ready)) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tap_reg       <= '0;
            m_valid_reg   <= 1'b0;
            tap_count_reg <= TAP_CNT_W'(1);
        end else begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                tap_count_reg <= cfg_wdata;
            end
        end
    end

endmodule

>>> hw/rtl/fbf_datapath.sv
// ----------------------------------------------------------------------------
// fbf_datapath: storage and arithmetic of the FIR band-pass filter unit
// Delay line and coefficient memories, a three-stage MAC pipeline, rounding,
// saturation and the result register.
// ----------------------------------------------------------------------------
module fbf_datapath
    import fbf_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fbf_cmd_t                       cmd,
    output fbf_status_t                    status,
    input  logic        [TAP_IDX_W-1:0]    s_coef_index,
    input  logic signed [COEF_WIDTH-1:0]   s_coef_value,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_value,
    output logic signed [SAMPLE_WIDTH-1:0] m_filtered_sample,
    output logic                           m_saturated
);

    localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] OUT_HI    = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_LO    = -OUT_HI - ACC_W'(1);

    logic signed [SAMPLE_WIDTH-1:0] dly_mem  [MAX_TAPS];
    logic signed [COEF_WIDTH-1:0]   coef_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]            dly_ok_reg;
    logic [MAX_TAPS-1:0]            coef_ok_reg;
    logic [TAP_IDX_W-1:0]           wp_reg;
    logic [TAP_IDX_W-1:0]           dly_addr;

    logic signed [SAMPLE_WIDTH-1:0] dly_rd_reg;
    logic signed [COEF_WIDTH-1:0]   coef_rd_reg;
    logic                           dly_rd_ok_reg, coef_rd_ok_reg;
    logic                           v1_reg, v2_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;

    logic signed [SAMPLE_WIDTH-1:0] dly_term;
    logic signed [COEF_WIDTH-1:0]   coef_term;
    logic signed [ACC_W-1:0]        rounded;
    logic signed [ACC_W-1:0]        shifted;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_next;
    logic                           out_sat_next;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_sat_reg;

    // Newest-first walk: tap m pairs with the sample m steps back.
    assign dly_addr  = wp_reg - cmd.tap_idx;
    assign dly_term  = dly_rd_ok_reg  ? dly_rd_reg  : '0;
    assign coef_term = coef_rd_ok_reg ? coef_rd_reg : '0;
    assign status.pipe_busy = v1_reg || v2_reg;

    // Memory writes and registered reads.
    always_ff @(posedge aclk) begin
        if (cmd.smp_wr) begin
            dly_mem[wp_reg] <= s_sample_value;
        end
        if (cmd.coef_wr) begin
            coef_mem[s_coef_index] <= s_coef_value;
        end
        dly_rd_reg  <= dly_mem[dly_addr];
        coef_rd_reg <= coef_mem[cmd.tap_idx];
    end

    // Entries never written read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dly_ok_reg  <= '0;
            coef_ok_reg <= '0;
            wp_reg      <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end else begin
            if (cmd.smp_wr) begin
                dly_ok_reg[wp_reg] <= 1'b1;
            end
            if (cmd.coef_wr) begin
                coef_ok_reg[s_coef_index] <= 1'b1;
            end
            if (cmd.load_out) begin
                wp_reg <= wp_reg + TAP_IDX_W'(1);
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dly_rd_ok_reg  <= dly_ok_reg[dly_addr];
        coef_rd_ok_reg <= coef_ok_reg[cmd.tap_idx];
        prod_reg       <= coef_term * dly_term;
        if (cmd.smp_wr) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // Round half up, then clip to the sample range.
    always_comb begin
        rounded = acc_reg + ROUND_ADD;
        shifted = rounded >>> ROUND_SHIFT;
        if (shifted > OUT_HI) begin
            out_sample_next = OUT_HI[SAMPLE_WIDTH-1:0];
            out_sat_next    = 1'b1;
        end else if (shifted < OUT_LO) begin
            out_sample_next = OUT_LO[SAMPLE_WIDTH-1:0];
            out_sat_next    = 1'b1;
        end else begin
            out_sample_next = shifted[SAMPLE_WIDTH-1:0];
            out_sat_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_sample_reg <= out_sample_next;
            out_sat_reg    <= out_sat_next;
        end
    end

    assign m_filtered_sample = out_sample_reg;
    assign m_saturated       = out_sat_reg;

endmodule

>>> hw/rtl/fir_bandpass_filter_unit.sv
// ----------------------------------------------------------------------------
// fir_bandpass_filter_unit: direct-form FIR filter over 16-bit audio samples
// A sample walks the taps of the one shared multiply-accumulate (taps is
// tap_count, limited to 64; with zero taps the sum is zero). The next
// request is taken in the cycle after the sample's result enters the output
// register, so a sample holds the multiply-accumulate until then. A
// coefficient write is stored on its transfer and leaves the unit idle.
// Synchronous active-low reset makes both tables read as zero, clears the
// pointer and sets tap_count to one.
// ----------------------------------------------------------------------------
module fir_bandpass_filter_unit
    import fbf_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request channel: a sample to filter or a coefficient write.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic        [TAP_IDX_W-1:0]    s_coef_index,
    input  logic signed [COEF_WIDTH-1:0]   s_coef_value,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_value,
    // Result channel: one transfer per sample request.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_filtered_sample,
    output logic                           m_saturated,
    // Configuration: the tap_count register.
    input  logic                           cfg_we,
    input  logic        [TAP_CNT_W-1:0]    cfg_wdata
);

    // The controller owns the handshakes and the tap counter. The datapath
    // owns the two memories and the multiply-accumulate pipeline, which it
    // reports back as busy until the last product has been summed.
    fbf_cmd_t    cmd;
    fbf_status_t status;

    fbf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .status     (status),
        .cmd        (cmd)
    );

    // The result stays in the datapath's output register until its transfer,
    // while the controller is already free to take the next request.
    fbf_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_coef_index      (s_coef_index),
        .s_coef_value      (s_coef_value),
        .s_sample_value    (s_sample_value),
        .m_filtered_sample (m_filtered_sample),
        .m_saturated       (m_saturated)
    );

endmodule

>>> verif/tb_fir_bandpass_filter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fir_bandpass_filter_unit: self-checking bench for the FIR filter unit
// A queue of requests feeds a clocked driver on the request channel, and a
// clocked monitor checks every result transfer against a bit-accurate filter
// model kept in the bench. Both channels stall in random bursts. The run
// steps through several tap counts, from zero taps up to the clamped maximum.
// ----------------------------------------------------------------------------
module tb_fir_bandpass_filter_unit;
    import fbf_pkg::*;

    // Cycles without any transfer before the run is declared hung. The limit
    // covers a sample's passage through the block, the idling of the source
    // and the sink, and each drain pause.
    localparam int HANG_LIMIT    = 4000;
    // Cycles allowed after the last result before a register write or the
    // end of the run, covering a full 64-tap pass plus the pipeline.
    localparam int DRAIN_CYCLES  = 80;
    localparam int REPORT_LIMIT  = 10;

    localparam logic signed [SAMPLE_WIDTH-1:0] WORD_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_WIDTH-1:0] WORD_MIN = 16'sh8000;

    typedef struct {
        logic                           req_type;
        logic        [TAP_IDX_W-1:0]    coef_index;
        logic signed [COEF_WIDTH-1:0]   coef_value;
        logic signed [SAMPLE_WIDTH-1:0] sample_value;
    } fir_req_t;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
        logic                           saturated;
    } fir_out_t;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                           aclk           = 1'b0;
    logic                           aresetn        = 1'b0;
    logic                           s_valid        = 1'b0;
    logic                           s_req_type     = REQ_SAMPLE;
    logic        [TAP_IDX_W-1:0]    s_coef_index   = '0;
    logic signed [COEF_WIDTH-1:0]   s_coef_value   = '0;
    logic signed [SAMPLE_WIDTH-1:0] s_sample_value = '0;
    logic                           m_ready        = 1'b0;
    logic                           cfg_we         = 1'b0;
    logic        [TAP_CNT_W-1:0]    cfg_wdata      = '0;
    logic                           s_ready;
    logic                           m_valid;
    logic signed [SAMPLE_WIDTH-1:0] m_filtered_sample;
    logic                           m_saturated;

    fir_bandpass_filter_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_coef_index      (s_coef_index),
        .s_coef_value      (s_coef_value),
        .s_sample_value    (s_sample_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_filtered_sample (m_filtered_sample),
        .m_saturated       (m_saturated),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Requests waiting to be driven and filter outputs waiting to be seen.
    fir_req_t pending_reqs[$];
    fir_out_t expected_outputs[$];

    // The bench's own copy of the filter state.
    logic signed [COEF_WIDTH-1:0]   model_coefs   [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] model_history [MAX_TAPS];
    int unsigned                    model_ptr;
    int unsigned                    model_taps;

    fir_req_t drive_req;
    bit       req_in_flight;
    bit       no_idling;
    int       src_gap;
    int       sink_stall;
    int       error_count;

    // Apply one accepted request to the model. A coefficient write only
    // updates the table. A sample enters the circular history at the
    // pointer, then the newest sample meets tap zero, the one before it
    // tap one, and so on. The sum is rounded half up at bit 15 and
    // clipped to the 16-bit range.
    task automatic apply_request(input fir_req_t r);
        longint      acc;
        longint      hi;
        longint      lo;
        int unsigned taps;
        int unsigned pos;
        fir_out_t    res;
        begin
            if (r.req_type == REQ_COEF) begin
                model_coefs[r.coef_index] = r.coef_value;
            end else begin
                model_history[model_ptr] = r.sample_value;
                // Counts above the table size use the whole table; zero
                // taps give a zero sum.
                taps = (model_taps > MAX_TAPS) ? MAX_TAPS : model_taps;
                acc = 0;
                for (int m = 0; m < taps; m++) begin
                    pos = (model_ptr + MAX_TAPS - m) % MAX_TAPS;
                    acc += longint'(model_coefs[m]) * longint'(model_history[pos]);
                end
                acc = (acc + (longint'(1) << (COEF_WIDTH - 2))) >>> (COEF_WIDTH - 1);
                hi = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
                lo = -hi - 1;
                res.saturated = 1'b0;
                if (acc > hi) begin
                    acc = hi;
                    res.saturated = 1'b1;
                end else if (acc < lo) begin
                    acc = lo;
                    res.saturated = 1'b1;
                end
                res.filtered_sample = acc[SAMPLE_WIDTH-1:0];
                expected_outputs.push_back(res);
                model_ptr = (model_ptr + 1) % MAX_TAPS;
            end
        end
    endtask

    // Request driver. A new request goes out once the previous one has been
    // transferred, sometimes after a burst of idle cycles. The model is
    // updated at the edge where the transfer happens.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
            req_in_flight = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(drive_req);
                req_in_flight = 1'b0;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    drive_req = pending_reqs.pop_front();
                    req_in_flight = 1'b1;
                    s_valid        <= 1'b1;
                    s_req_type     <= drive_req.req_type;
                    s_coef_index   <= drive_req.coef_index;
                    s_coef_value   <= drive_req.coef_value;
                    s_sample_value <= drive_req.sample_value;
                    if (!no_idling && $urandom_range(0, 7) == 0) begin
                        src_gap = $urandom_range(1, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result sink. It holds off in random bursts, so results are
    // held at the output register for varying lengths of time.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_stall = 0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= 1'b0;
        end else if (!no_idling && $urandom_range(0, 9) == 0) begin
            sink_stall = $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result monitor: each result transfer is checked against the oldest
    // filter output still expected.
    always @(posedge aclk) begin
        fir_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("%0t: result with none expected: sample %0d saturated %0b",
                             $realtime, m_filtered_sample, m_saturated);
                end
            end else begin
                want = expected_outputs.pop_front();
                if (m_filtered_sample !== want.filtered_sample ||
                    m_saturated !== want.saturated) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch: sample %0d saturated %0b, expected %0d %0b",
                                 $realtime, m_filtered_sample, m_saturated,
                                 want.filtered_sample, want.saturated);
                    end
                end
            end
        end
    end

    // Hang detection: any transfer or register write restarts the count.
    always @(posedge aclk) begin
        int quiet_cycles;
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Random word, weighted toward the extremes and toward small magnitudes
    // so that both clipped and unclipped sums are frequent.
    function automatic logic signed [SAMPLE_WIDTH-1:0] shaped_word();
        logic signed [SAMPLE_WIDTH-1:0] w;
        begin
            w = SAMPLE_WIDTH'($urandom);
            case ($urandom_range(0, 7))
                0: w = WORD_MAX;
                1: w = WORD_MIN;
                2, 3: ;
                default: w = w >>> $urandom_range(3, 12);
            endcase
            return w;
        end
    endfunction

    // The fields a request does not use carry random junk.
    function automatic fir_req_t coef_req(input int idx, input logic signed [15:0] val);
        fir_req_t r;
        begin
            r.req_type     = REQ_COEF;
            r.coef_index   = TAP_IDX_W'(idx);
            r.coef_value   = val;
            r.sample_value = SAMPLE_WIDTH'($urandom);
            return r;
        end
    endfunction

    function automatic fir_req_t sample_req(input logic signed [15:0] val);
        fir_req_t r;
        begin
            r.req_type     = REQ_SAMPLE;
            r.coef_index   = TAP_IDX_W'($urandom);
            r.coef_value   = COEF_WIDTH'($urandom);
            r.sample_value = val;
            return r;
        end
    endfunction

    // Wait until every request has been transferred and every result seen,
    // then let a full filter pass go by in case a late result is pending.
    task automatic drain();
        begin
            while (pending_reqs.size() != 0 || req_in_flight ||
                   expected_outputs.size() != 0) begin
                @(posedge aclk);
            end
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end
    endtask

    // Register write; only called while the block is idle.
    task automatic write_taps(input int count);
        begin
            @(posedge aclk);
            cfg_we    <= 1'b1;
            cfg_wdata <= TAP_CNT_W'(count);
            model_taps = count;
            @(posedge aclk);
            cfg_we    <= 1'b0;
        end
    endtask

    // One random phase: about a fifth coefficient writes, the rest samples.
    task automatic random_phase(input int count, input int n, input bit calm);
        begin
            write_taps(count);
            no_idling = calm;
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    pending_reqs.push_back(coef_req($urandom_range(0, MAX_TAPS - 1),
                                                    shaped_word()));
                end else begin
                    pending_reqs.push_back(sample_req(shaped_word()));
                end
            end
            drain();
        end
    endtask

    initial begin
        for (int k = 0; k < MAX_TAPS; k++) begin
            model_coefs[k]   = '0;
            model_history[k] = '0;
        end
        model_ptr   = 0;
        model_taps  = 1;
        no_idling   = 1'b0;
        error_count = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, still at the reset tap count of one. Full-scale
        // products, the one single-tap product that clips, and rounding of
        // exact halves in both directions.
        pending_reqs.push_back(coef_req(0, WORD_MAX));
        pending_reqs.push_back(sample_req(WORD_MAX));
        pending_reqs.push_back(sample_req(WORD_MIN));
        pending_reqs.push_back(sample_req(16'sd0));
        pending_reqs.push_back(coef_req(0, WORD_MIN));
        pending_reqs.push_back(sample_req(WORD_MIN));
        pending_reqs.push_back(sample_req(WORD_MAX));
        pending_reqs.push_back(coef_req(0, 16'sd1));
        pending_reqs.push_back(sample_req(16'sd16384));
        pending_reqs.push_back(sample_req(-16'sd16384));
        pending_reqs.push_back(sample_req(-16'sd16385));
        pending_reqs.push_back(coef_req(0, WORD_MIN));
        pending_reqs.push_back(coef_req(1, WORD_MIN));
        pending_reqs.push_back(coef_req(MAX_TAPS - 1, WORD_MIN));
        drain();

        // Zero taps: the output is zero, but samples still enter the history.
        write_taps(0);
        pending_reqs.push_back(sample_req(WORD_MAX));
        pending_reqs.push_back(sample_req(WORD_MAX));
        drain();

        // Two taps at minus full scale over two full-scale samples clip low.
        write_taps(2);
        pending_reqs.push_back(sample_req(WORD_MAX));
        pending_reqs.push_back(sample_req(WORD_MAX));
        drain();

        // A count above the table size uses all 64 taps, the last one too.
        write_taps(127);
        pending_reqs.push_back(sample_req(WORD_MIN));
        pending_reqs.push_back(sample_req(WORD_MAX));
        pending_reqs.push_back(sample_req(16'sd0));
        drain();

        // Random part over a spread of tap counts. The final phase runs
        // with both sides always willing.
        random_phase(64, 150, 1'b0);
        random_phase(1, 120, 1'b0);
        random_phase(33, 150, 1'b0);
        random_phase(0, 60, 1'b0);
        random_phase(127, 120, 1'b0);
        random_phase(65, 80, 1'b0);
        random_phase(17, 150, 1'b0);
        random_phase(3, 150, 1'b0);
        random_phase(64, 250, 1'b1);

        // Anything still expected at this point never arrived.
        error_count += expected_outputs.size();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
